### design/mfr_pkg.sv
// Package for the maximal free rectangle block: sizes, the sequencer state
// type, register indexes and the stack entry layout. No dependencies.
`timescale 1ns / 1ps

package mfr_pkg;

  // Grid limits
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // Field widths
  localparam int CFG_W     = 7;                         // grid_rows / grid_cols
  localparam int CFG_IDX_W = 1;                         // two registers
  localparam int COL_W     = $clog2(MAX_COLS);          // column index
  localparam int ROW_W     = $clog2(MAX_ROWS);          // row index
  localparam int HGT_W     = $clog2(MAX_ROWS + 1);      // run height 0..MAX_ROWS
  localparam int EDGE_W    = $clog2(MAX_COLS + 1);      // rectangle edge 0..MAX_COLS
  localparam int PROD_W    = HGT_W + EDGE_W;            // height times width
  localparam int AREA_W    = 13;
  localparam int DEPTH_W   = $clog2(MAX_COLS + 2);      // stack fill 0..MAX_COLS

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  // One stack entry: column and its run height (heights do not change
  // while a column sits on the stack, so the height travels with it)
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [HGT_W-1:0] hgt;
  } stk_entry_t;

  localparam int STK_W = $bits(stk_entry_t);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HREAD,
    ST_POP_CHECK,
    ST_POP_LOAD,
    ST_PUSH,
    ST_ROW_END
  } state_t;

endpackage

### design/mfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the column heights and the column stack; no dependencies.
`timescale 1ns / 1ps

module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/maximal_free_rectangle.sv
// Maximal free rectangle: column run heights and a monotonic column stack (mfr_pkg, mfr_ram),
// one cell per transfer, area result after the final cell. Busy stays high through a cell's
// height read, pops and push; a row end adds the stack flush, each pop being a stack RAM read
// then one multiply on the shared unit. A new cell is taken only when busy is low; the result
// strobe follows the row end state in the next cycle, and the receiver cannot stall.
// Reset (rst_n low, synchronous) clears heights, stack and best area; dimensions go to 64.
`timescale 1ns / 1ps

module maximal_free_rectangle (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_blocked,
  // result channel
  output logic                          out_valid,
  output logic [mfr_pkg::AREA_W-1:0]    out_max_area,
  // configuration
  input  logic                          cfg_we,
  input  logic [mfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfr_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int COL_W   = mfr_pkg::COL_W;
  localparam int ROW_W   = mfr_pkg::ROW_W;
  localparam int HGT_W   = mfr_pkg::HGT_W;
  localparam int EDGE_W  = mfr_pkg::EDGE_W;
  localparam int PROD_W  = mfr_pkg::PROD_W;
  localparam int AREA_W  = mfr_pkg::AREA_W;
  localparam int DEPTH_W = mfr_pkg::DEPTH_W;
  localparam int CFG_W   = mfr_pkg::CFG_W;

  // ---------------------------------------------------------------------
  // Registers
  mfr_pkg::state_t           state_r, state_nxt;
  logic                      blocked_r;
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [DEPTH_W-1:0]        depth_r, depth_nxt;
  mfr_pkg::stk_entry_t       top_r, top_nxt;
  logic [HGT_W-1:0]          thr_r, thr_nxt;         // pop threshold
  logic [EDGE_W-1:0]         right_r, right_nxt;     // exclusive right edge
  logic                      flush_r, flush_nxt;     // popping for row end
  logic [HGT_W-1:0]          popped_r, popped_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic                      prod_v_r, prod_v_nxt;
  logic [AREA_W-1:0]         best_r, best_nxt;
  logic [mfr_pkg::MAX_COLS-1:0] hvalid_r, hvalid_nxt;
  logic [CFG_W-1:0]          rows_r, cols_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [AREA_W-1:0]         out_area_r, out_area_nxt;

  // RAM ports
  logic                      h_we;
  logic [HGT_W-1:0]          h_wdata, h_rdata;
  logic                      s_we;
  logic [COL_W-1:0]          s_waddr, s_raddr;
  mfr_pkg::stk_entry_t       s_wdata, s_rdata;
  logic [mfr_pkg::STK_W-1:0] s_rdata_raw;

  // Helpers
  logic [CFG_W-1:0]          rows_eff, cols_eff;
  logic [HGT_W-1:0]          old_h, new_h;
  logic [EDGE_W-1:0]         left_edge, width;
  logic [AREA_W-1:0]         prod_sat;
  logic                      accept;

  assign accept = start && (state_r == mfr_pkg::ST_IDLE);
  assign busy   = (state_r != mfr_pkg::ST_IDLE);

  // Column run heights
  mfr_ram #(.WIDTH(HGT_W), .DEPTH(mfr_pkg::MAX_COLS)) u_height (
    .clk   (clk),
    .we    (h_we),
    .waddr (col_r),
    .wdata (h_wdata),
    .raddr (col_r),
    .rdata (h_rdata)
  );

  // Column stack below and including the top
  mfr_ram #(.WIDTH(mfr_pkg::STK_W), .DEPTH(mfr_pkg::MAX_COLS)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata_raw)
  );
  assign s_rdata = mfr_pkg::stk_entry_t'(s_rdata_raw);

  // Dimensions clamped to 1..MAX
  always_comb begin
    if (rows_r == '0) begin
      rows_eff = CFG_W'(1);
    end else if (rows_r > CFG_W'(mfr_pkg::MAX_ROWS)) begin
      rows_eff = CFG_W'(mfr_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
    if (cols_r == '0) begin
      cols_eff = CFG_W'(1);
    end else if (cols_r > CFG_W'(mfr_pkg::MAX_COLS)) begin
      cols_eff = CFG_W'(mfr_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
  end

  // New run height of the current column
  assign old_h = hvalid_r[col_r] ? h_rdata : '0;
  always_comb begin
    if (blocked_r) begin
      new_h = '0;
    end else if (old_h < HGT_W'(mfr_pkg::MAX_ROWS)) begin
      new_h = old_h + HGT_W'(1);
    end else begin
      new_h = old_h;
    end
  end

  // Left edge from the entry now on top after a pop, and rectangle width
  assign left_edge = (depth_r != '0) ? EDGE_W'(s_rdata.col) + EDGE_W'(1) : '0;
  assign width     = right_r - left_edge;

  // Saturated area of the registered product
  assign prod_sat = (prod_r > PROD_W'(mfr_pkg::AREA_MAX)) ? mfr_pkg::AREA_MAX
                                                          : AREA_W'(prod_r);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      depth_r     <= '0;
      prod_v_r    <= 1'b0;
      best_r      <= '0;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      depth_r     <= depth_nxt;
      prod_v_r    <= prod_v_nxt;
      best_r      <= best_nxt;
      hvalid_r    <= hvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      blocked_r <= in_blocked;
    end
    top_r      <= top_nxt;
    thr_r      <= thr_nxt;
    right_r    <= right_nxt;
    flush_r    <= flush_nxt;
    popped_r   <= popped_nxt;
    prod_r     <= prod_nxt;
    out_area_r <= out_area_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(mfr_pkg::MAX_ROWS);
      cols_r <= CFG_W'(mfr_pkg::MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        mfr_pkg::REG_GRID_ROWS: rows_r <= cfg_wdata;
        mfr_pkg::REG_GRID_COLS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    depth_nxt     = depth_r;
    top_nxt       = top_r;
    thr_nxt       = thr_r;
    right_nxt     = right_r;
    flush_nxt     = flush_r;
    popped_nxt    = popped_r;
    prod_nxt      = prod_r;
    prod_v_nxt    = 1'b0;
    best_nxt      = best_r;
    hvalid_nxt    = hvalid_r;
    out_valid_nxt = 1'b0;
    out_area_nxt  = out_area_r;
    h_we          = 1'b0;
    h_wdata       = new_h;
    s_we          = 1'b0;
    s_waddr       = depth_r[COL_W-1:0];
    s_wdata       = top_r;
    s_raddr       = COL_W'(depth_r - DEPTH_W'(2));

    // Fold in the product from the previous pop
    if (prod_v_r && (prod_sat > best_r)) begin
      best_nxt = prod_sat;
    end

    case (state_r)
      mfr_pkg::ST_IDLE: begin
        // height RAM is read at col_r this cycle
        if (accept) begin
          state_nxt = mfr_pkg::ST_HREAD;
        end
      end

      mfr_pkg::ST_HREAD: begin
        h_we               = 1'b1;
        hvalid_nxt[col_r]  = 1'b1;
        thr_nxt            = new_h;
        right_nxt          = EDGE_W'(col_r);
        flush_nxt          = 1'b0;
        top_nxt            = top_r;
        state_nxt          = mfr_pkg::ST_POP_CHECK;
      end

      mfr_pkg::ST_POP_CHECK: begin
        if ((depth_r != '0) && (top_r.hgt > thr_r)) begin
          // pop: new top is read from the stack RAM at depth-2
          popped_nxt = top_r.hgt;
          depth_nxt  = depth_r - DEPTH_W'(1);
          state_nxt  = mfr_pkg::ST_POP_LOAD;
        end else if (flush_r) begin
          state_nxt  = mfr_pkg::ST_ROW_END;
        end else begin
          state_nxt  = mfr_pkg::ST_PUSH;
        end
      end

      mfr_pkg::ST_POP_LOAD: begin
        if (depth_r != '0) begin
          top_nxt = s_rdata;
        end
        prod_nxt   = PROD_W'(popped_r) * PROD_W'(width);
        prod_v_nxt = 1'b1;
        state_nxt  = mfr_pkg::ST_POP_CHECK;
      end

      mfr_pkg::ST_PUSH: begin
        s_we        = 1'b1;
        s_wdata.col = col_r;
        s_wdata.hgt = thr_r;
        top_nxt     = s_wdata;
        depth_nxt   = depth_r + DEPTH_W'(1);
        if (CFG_W'(col_r) + CFG_W'(1) >= cols_eff) begin
          // row end: flush every column of nonzero height against threshold zero
          thr_nxt   = '0;
          right_nxt = EDGE_W'(col_r) + EDGE_W'(1);
          flush_nxt = 1'b1;
          state_nxt = mfr_pkg::ST_POP_CHECK;
        end else begin
          col_nxt   = col_r + COL_W'(1);
          state_nxt = mfr_pkg::ST_IDLE;
        end
      end

      mfr_pkg::ST_ROW_END: begin
        depth_nxt = '0;
        col_nxt   = '0;
        if (CFG_W'(row_r) + CFG_W'(1) >= rows_eff) begin
          // grid end: emit best area and clear the grid state
          out_valid_nxt = 1'b1;
          out_area_nxt  = best_r;
          best_nxt      = '0;
          hvalid_nxt    = '0;
          row_nxt       = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
        state_nxt = mfr_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = mfr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_max_area = out_area_r;

`ifndef ASSERT_OFF
  // A result only follows a row end
  a_out_after_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == mfr_pkg::ST_ROW_END)
    else $error("result without a row end");

  // A pending product is always folded in before the sequencer goes idle
  a_no_prod_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfr_pkg::ST_IDLE) |-> !prod_v_r)
    else $error("product pending while idle");

  // Stack never holds more columns than a row has
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(mfr_pkg::MAX_COLS))
    else $error("stack overflow");

  // The stack is empty whenever a new row begins
  a_stack_empty_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (col_r == '0)) |-> (depth_r == '0))
    else $error("stack not empty at row start");
`endif

endmodule
